// ----- src/wcs_pkg.sv -----
// shared types and constants of the window comparator stepper
package wcs_pkg;

    // fixed point: 1024 lsb per volt
    localparam int VMAX      = 10240;
    localparam int STEP_MAX  = 5120;
    localparam int ONE_VOLT  = 1024;
    localparam int BAR_STEPS = 10;

    localparam int V_W       = 15;                         // accumulator and bias
    localparam int RANGE_W   = 14;                         // effective range
    localparam int STEP_W    = 14;                         // effective step
    localparam int X2_W      = 18;                         // doubled values
    localparam int NUM_W     = $clog2(BAR_STEPS * 5 * VMAX + 1);
    localparam int DEN_W     = RANGE_W + 1;
    localparam int BAR_CNT_W = $clog2(BAR_STEPS + 1);
    localparam int BAR_W     = 4;

    localparam int IN_W      = 120;
    localparam int OUT_W     = 24;
    localparam int ADDR_W    = 4;

    // register indexes
    localparam logic [1:0] REG_BIAS  = 2'd0;
    localparam logic [1:0] REG_RANGE = 2'd1;
    localparam logic [1:0] REG_STEP  = 2'd2;
    localparam logic [1:0] REG_EXT   = 2'd3;

    typedef struct packed {
        logic [13:0] bias_knob;
        logic [13:0] range_knob;
        logic [11:0] step_knob;
        logic        external_source;
    } wcs_cfg_t;

    typedef struct packed {
        logic capture;
        logic resolve;
        logic walls;
        logic update;
        logic prep;
        logic div_step;
        logic publish;
    } wcs_cmd_t;

    typedef struct packed {
        logic div_done;
    } wcs_stat_t;

endpackage

// ----- src/window_comparator_stepper.sv -----
// top level of the window comparator stepper
// One transaction on the input stream carries the control voltages of one
// sample (signed, 1024 lsb per volt) and yields exactly one result
// transaction. The block works on one sample at a time: after an input
// transaction it clamps the controls, builds the window walls, tests and
// updates the accumulator and forms the bar numerator, in that order, then
// the bar level divider subtracts once per cycle until the bar level is
// found, and at last the output register is loaded. The repeated subtraction
// of the bar divider makes the time a sample takes depend on its bar level.
// The result sits in an output register, so the next sample is accepted
// while it waits; a sample only holds in its output state while the
// result before it has not been taken yet. Knob registers are written over
// the apb port at byte address 4*index and should change only while the
// block is idle.
module window_comparator_stepper
    import wcs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    // [15:0] signal_sample, [31:16] bias_cv, [47:32] range_cv, [63:48] step_cv,
    // [79:64] invert_cv, [95:80] trigger_cv, [111:96] reset_cv,
    // [112] trigger_button, [113] reset_button, [119:114] zero
    input  logic [IN_W-1:0]   s_tdata,
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    // [0] above_window, [1] below_window, [16:2] stepper_value,
    // [20:17] bar_level, [21] edge_seen, [23:22] zero
    output logic [OUT_W-1:0]  m_tdata,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    wcs_cfg_t  cfg;
    wcs_cmd_t  cmd;
    wcs_stat_t stat;

    // knob registers
    wcs_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: one step per stage, then waits on the divider and on the result stream
    wcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // arithmetic, accumulator state and output register
    wcs_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .stat    (stat),
        .m_tdata (m_tdata)
    );

endmodule

// ----- src/wcs_regs.sv -----
// apb register file holding the knob settings
module wcs_regs
    import wcs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output wcs_cfg_t          cfg
);

    wcs_cfg_t   cfg_reg;
    logic [1:0] idx;
    logic       wr_en;

    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bias_knob       <= 14'd1024;
            cfg_reg.range_knob      <= 14'd3072;
            cfg_reg.step_knob       <= 12'd427;
            cfg_reg.external_source <= 1'b0;
        end else if (wr_en) begin
            unique case (idx)
                REG_BIAS:  cfg_reg.bias_knob       <= pwdata[13:0];
                REG_RANGE: cfg_reg.range_knob      <= pwdata[13:0];
                REG_STEP:  cfg_reg.step_knob       <= pwdata[11:0];
                REG_EXT:   cfg_reg.external_source <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_BIAS:  prdata = {18'd0, cfg_reg.bias_knob};
            REG_RANGE: prdata = {18'd0, cfg_reg.range_knob};
            REG_STEP:  prdata = {20'd0, cfg_reg.step_knob};
            REG_EXT:   prdata = {31'd0, cfg_reg.external_source};
            default:   prdata = 32'd0;
        endcase
    end

endmodule

// ----- src/wcs_ctrl.sv -----
// sequencing state machine and output valid
module wcs_ctrl
    import wcs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  wcs_stat_t stat,
    output wcs_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOAD, ST_WALL, ST_EVAL, ST_PREP, ST_DIV, ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.resolve = 1'b1;
                state_next  = ST_WALL;
            end
            ST_WALL: begin
                cmd.walls  = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                cmd.update = 1'b1;
                state_next = ST_PREP;
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (stat.div_done) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.publish  = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- src/wcs_datapath.sv -----
// clamping, window test, accumulator and bar level divider
module wcs_datapath
    import wcs_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  wcs_cfg_t         cfg,
    input  logic [IN_W-1:0]  s_tdata,
    input  wcs_cmd_t         cmd,
    output wcs_stat_t        stat,
    output logic [OUT_W-1:0] m_tdata
);

    // captured sample
    logic signed [15:0] sample_reg, bias_cv_reg, range_cv_reg, step_cv_reg;
    logic signed [15:0] invert_cv_reg, trig_cv_reg, rst_cv_reg;
    logic               trig_btn_reg, rst_btn_reg;

    // effective controls
    logic signed [V_W-1:0]    bias_reg;
    logic [RANGE_W-1:0]       range_reg;
    logic signed [STEP_W-1:0] step_reg;
    logic                     trig_reg, rst_reg;

    // walls
    logic signed [X2_W-1:0] up2_reg, lo2_reg, x2_reg;

    // state
    logic signed [V_W-1:0] acc_reg, acc_next;
    logic                  last_trig_reg, last_rst_reg;
    logic                  above_reg, below_reg, edge_reg;

    // divider
    logic [NUM_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [BAR_CNT_W-1:0] q_reg;
    logic                 n_pos_reg;

    logic [OUT_W-1:0] out_reg;

    // resolve stage
    logic signed [16:0] bias_sum, range_sum, step_sum, range_abs;
    logic signed [V_W-1:0]    bias_eff;
    logic [RANGE_W-1:0]       range_eff;
    logic signed [STEP_W-1:0] step_clamp, step_eff;
    logic                     invert;

    always_comb begin
        bias_sum  = 17'(signed'(cfg.bias_knob)) + 17'(bias_cv_reg);
        range_sum = signed'({3'd0, cfg.range_knob}) + 17'(range_cv_reg);
        step_sum  = 17'(signed'(cfg.step_knob)) + 17'(step_cv_reg);
        range_abs = range_sum[16] ? -range_sum : range_sum;
        invert    = (int'(invert_cv_reg) > 0);

        if (int'(bias_sum) > VMAX)       bias_eff = V_W'(VMAX);
        else if (int'(bias_sum) < -VMAX) bias_eff = V_W'(-VMAX);
        else                             bias_eff = bias_sum[V_W-1:0];

        if (int'(range_abs) > VMAX) range_eff = RANGE_W'(VMAX);
        else                        range_eff = range_abs[RANGE_W-1:0];

        if (int'(step_sum) > STEP_MAX)       step_clamp = STEP_W'(STEP_MAX);
        else if (int'(step_sum) < -STEP_MAX) step_clamp = STEP_W'(-STEP_MAX);
        else                                 step_clamp = step_sum[STEP_W-1:0];
        step_eff = invert ? -step_clamp : step_clamp;
    end

    // evaluate stage
    logic                  above, below, trig_edge, rst_edge, use_corr;
    logic signed [15:0]    delta, acc_sum;
    logic signed [V_W-1:0] acc_stepped;

    always_comb begin
        if (cfg.external_source) begin
            above = x2_reg > up2_reg;
            below = !above && (x2_reg < lo2_reg);
        end else if (!step_reg[STEP_W-1]) begin
            above = x2_reg >= up2_reg;
            below = !above && (x2_reg < lo2_reg);
        end else begin
            above = x2_reg > up2_reg;
            below = !above && (x2_reg <= lo2_reg);
        end
        use_corr = !cfg.external_source && (above || below) && (range_reg != '0);
        if (use_corr) begin
            delta = above ? -signed'({2'd0, range_reg}) : signed'({2'd0, range_reg});
        end else begin
            delta = 16'(step_reg);
        end
        acc_sum = 16'(acc_reg) + delta;
        if (int'(acc_sum) > VMAX)       acc_stepped = V_W'(VMAX);
        else if (int'(acc_sum) < -VMAX) acc_stepped = V_W'(-VMAX);
        else                            acc_stepped = acc_sum[V_W-1:0];

        trig_edge = trig_reg && !last_trig_reg;
        rst_edge  = rst_reg && !last_rst_reg;
        acc_next  = acc_reg;
        if (rst_edge) begin
            acc_next = cfg.external_source ? '0 : bias_reg;
        end else if (trig_edge) begin
            acc_next = acc_stepped;
        end
    end

    // bar level numerator
    logic signed [X2_W-1:0] n_val;
    logic                   n_pos;

    always_comb begin
        n_val = X2_W'((int'(acc_reg) <<< 1) - (int'(bias_reg) <<< 1) + int'(range_reg));
        n_pos = (int'(n_val) > 0);
    end

    logic [BAR_CNT_W+BAR_W-1:0] bar_wide;

    assign stat.div_done = !n_pos_reg || (q_reg == BAR_CNT_W'(BAR_STEPS))
                           || (rem_reg < NUM_W'(den_reg));
    assign bar_wide      = {{BAR_W{1'b0}}, q_reg};
    assign m_tdata       = out_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sample_reg    <= s_tdata[15:0];
            bias_cv_reg   <= s_tdata[31:16];
            range_cv_reg  <= s_tdata[47:32];
            step_cv_reg   <= s_tdata[63:48];
            invert_cv_reg <= s_tdata[79:64];
            trig_cv_reg   <= s_tdata[95:80];
            rst_cv_reg    <= s_tdata[111:96];
            trig_btn_reg  <= s_tdata[112];
            rst_btn_reg   <= s_tdata[113];
        end
        if (cmd.resolve) begin
            bias_reg  <= bias_eff;
            range_reg <= range_eff;
            step_reg  <= step_eff;
            trig_reg  <= (int'(trig_cv_reg) > ONE_VOLT) || trig_btn_reg;
            rst_reg   <= (int'(rst_cv_reg) > ONE_VOLT) || rst_btn_reg;
        end
        if (cmd.walls) begin
            up2_reg <= X2_W'((int'(bias_reg) <<< 1) + int'(range_reg));
            lo2_reg <= X2_W'((int'(bias_reg) <<< 1) - int'(range_reg));
            x2_reg  <= cfg.external_source ? X2_W'(int'(sample_reg) <<< 1)
                                           : X2_W'(int'(acc_reg) <<< 1);
        end
        if (cmd.update) begin
            above_reg <= above;
            below_reg <= below;
            edge_reg  <= trig_edge || rst_edge;
        end
        if (cmd.prep) begin
            n_pos_reg <= n_pos;
            rem_reg   <= n_pos ? NUM_W'(BAR_STEPS * int'(n_val)) : '0;
            den_reg   <= {range_reg, 1'b0};
            q_reg     <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= rem_reg - NUM_W'(den_reg);
            q_reg   <= q_reg + BAR_CNT_W'(1);
        end
        if (cmd.publish) begin
            out_reg <= {2'd0, edge_reg, bar_wide[BAR_W-1:0], acc_reg, below_reg, above_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= V_W'(ONE_VOLT);
            last_trig_reg <= 1'b0;
            last_rst_reg  <= 1'b0;
        end else if (cmd.update) begin
            acc_reg       <= acc_next;
            last_trig_reg <= trig_reg;
            last_rst_reg  <= rst_reg;
        end
    end

endmodule

// ----- src/wcs_checker.sv -----
// port level checks for the window comparator stepper
module wcs_checker
    import wcs_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    // a stalled result holds its data
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one sample at a time: no input right after an input transaction
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a sample is in work");

    // accumulator stays within the rails
    a_acc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (int'($signed(m_tdata[16:2])) <= VMAX)
                  && (int'($signed(m_tdata[16:2])) >= -VMAX))
        else $error("stepper value beyond rails");

    // a value cannot sit on both sides of the window
    a_side: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("above and below both set");

endmodule

bind window_comparator_stepper wcs_checker u_chk (.*);

// ----- bench/testbench.sv -----
// self-checking testbench of the window comparator stepper
`timescale 1ns / 1ps

module testbench;
    import wcs_pkg::*;

    // one predicted result transaction
    typedef struct {
        logic        above;
        logic        below;
        logic [14:0] value;
        logic [3:0]  bar;
        logic        edge_seen;
    } window_result_t;

    // keeps its own copy of the knobs and the stepper state and predicts the
    // result of every accepted sample
    class stepper_scoreboard;
        int             bias_knob;
        int             range_knob;
        int             step_knob;
        bit             external_source;
        int             acc;
        bit             trig_prev;
        bit             rst_prev;
        int             failures;
        window_result_t predicted[$];

        function new();
            bias_knob       = 1024;
            range_knob      = 3072;
            step_knob       = 427;
            external_source = 1'b0;
            acc             = 1024;
            trig_prev       = 1'b0;
            rst_prev        = 1'b0;
            failures        = 0;
        endfunction

        function int clamp(int v, int lo, int hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function int cv_field(logic [IN_W-1:0] d, int k);
            logic signed [15:0] v;
            v = d[16*k +: 16];
            return v;
        endfunction

        function int pending();
            return predicted.size();
        endfunction

        function void set_knob(logic [1:0] idx, logic [31:0] v);
            logic signed [13:0] b14;
            logic signed [11:0] s12;
            b14 = v[13:0];
            s12 = v[11:0];
            case (idx)
                REG_BIAS:  bias_knob = b14;
                REG_RANGE: range_knob = v[13:0];
                REG_STEP:  step_knob = s12;
                REG_EXT:   external_source = v[0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic [IN_W-1:0] d);
            int             smp, bias, rng, stp, up2, lo2, x2, corr, num, quo;
            bit             invert, trig, rst, ext, above, below;
            window_result_t r;
            smp    = cv_field(d, 0);
            bias   = clamp(bias_knob + cv_field(d, 1), -VMAX, VMAX);
            rng    = range_knob + cv_field(d, 2);
            if (rng < 0)
                rng = -rng;
            rng    = clamp(rng, 0, VMAX);
            stp    = clamp(step_knob + cv_field(d, 3), -STEP_MAX, STEP_MAX);
            invert = cv_field(d, 4) > 0;
            trig   = cv_field(d, 5) > ONE_VOLT || d[112];
            rst    = cv_field(d, 6) > ONE_VOLT || d[113];
            ext    = external_source;
            if (invert)
                stp = -stp;

            // walls on doubled values; step sign sets inclusivity, external mode exclusive
            up2 = 2 * bias + rng;
            lo2 = 2 * bias - rng;
            x2  = 2 * (ext ? smp : acc);
            if (ext || stp < 0)
                above = x2 > up2;
            else
                above = x2 >= up2;
            if (ext || stp >= 0)
                below = !above && x2 < lo2;
            else
                below = !above && x2 <= lo2;
            corr = 0;
            if (!ext)
                corr = above ? -rng : (below ? rng : 0);

            r.edge_seen = 1'b0;
            if (trig && !trig_prev) begin
                acc = clamp(acc + (corr != 0 ? corr : stp), -VMAX, VMAX);
                r.edge_seen = 1'b1;
            end
            if (rst && !rst_prev) begin
                acc = ext ? 0 : bias;
                r.edge_seen = 1'b1;
            end
            trig_prev = trig;
            rst_prev  = rst;

            num = 2 * acc - 2 * bias + rng;
            if (rng == 0)
                quo = num > 0 ? BAR_STEPS : 0;
            else if (num <= 0)
                quo = 0;
            else begin
                quo = (BAR_STEPS * num) / (2 * rng);
                if (quo > BAR_STEPS)
                    quo = BAR_STEPS;
            end

            r.above = above;
            r.below = below;
            r.value = acc[14:0];
            r.bar   = quo[3:0];
            predicted.push_back(r);
        endfunction

        function void check_output(logic [OUT_W-1:0] t);
            window_result_t want;
            if (predicted.size() == 0) begin
                $error("result transaction with no sample pending: %h", t);
                failures++;
                return;
            end
            want = predicted.pop_front();
            if (t[0] !== want.above) begin
                $error("above_window expected %0d got %0d", want.above, t[0]);
                failures++;
            end
            if (t[1] !== want.below) begin
                $error("below_window expected %0d got %0d", want.below, t[1]);
                failures++;
            end
            if (t[16:2] !== want.value) begin
                $error("stepper_value expected %0d got %0d",
                       $signed(want.value), $signed(t[16:2]));
                failures++;
            end
            if (t[20:17] !== want.bar) begin
                $error("bar_level expected %0d got %0d", want.bar, t[20:17]);
                failures++;
            end
            if (t[21] !== want.edge_seen) begin
                $error("edge_seen expected %0d got %0d", want.edge_seen, t[21]);
                failures++;
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    // [15:0] signal_sample, [31:16] bias_cv, [47:32] range_cv, [63:48] step_cv,
    // [79:64] invert_cv, [95:80] trigger_cv, [111:96] reset_cv,
    // [112] trigger_button, [113] reset_button, [119:114] zero
    logic [IN_W-1:0]   s_tdata   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    // [0] above_window, [1] below_window, [16:2] stepper_value,
    // [20:17] bar_level, [21] edge_seen, [23:22] zero
    logic [OUT_W-1:0]  m_tdata;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [31:0]       pwdata    = '0;
    logic [31:0]       prdata;
    logic              pready;

    stepper_scoreboard sb;

    // idling knobs of the current phase, in percent
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // remaining cycles of a forced receiver hold-off
    int hold_cycles    = 0;

    window_comparator_stepper dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // generous limit: the slowest run needs well under a tenth of this
    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver: random stalls, or a long hold-off counted here
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // every result transaction is checked against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_output(m_tdata);
    end

    // build one input transaction from its fields
    function automatic logic [IN_W-1:0] pack_sample(int sig, int bias, int rng, int stp,
                                                    int inv, int trg, int rst,
                                                    bit tb, bit rb);
        logic [IN_W-1:0] d;
        d            = '0;
        d[15:0]      = sig[15:0];
        d[31:16]     = bias[15:0];
        d[47:32]     = rng[15:0];
        d[63:48]     = stp[15:0];
        d[79:64]     = inv[15:0];
        d[95:80]     = trg[15:0];
        d[111:96]    = rst[15:0];
        d[112]       = tb;
        d[113]       = rb;
        return d;
    endfunction

    // control voltage: moderate half the time, else zero or any pattern
    function automatic int pick_cv(int spread);
        logic signed [15:0] raw;
        raw = 16'($urandom());
        case ($urandom_range(3))
            0:       return raw;
            1:       return 0;
            default: return int'($urandom_range(2 * spread)) - spread;
        endcase
    endfunction

    // random sample shaped so triggers see frequent rising edges and resets occasional ones
    function automatic logic [IN_W-1:0] random_sample();
        int sig, trg, rst;
        sig = ($urandom_range(3) == 0) ? pick_cv(32767)
                                       : int'($urandom_range(24000)) - 12000;
        case ($urandom_range(7))
            0:       trg = pick_cv(32767);
            1:       trg = ONE_VOLT;
            2:       trg = ONE_VOLT + 1;
            default: trg = $urandom_range(2047);
        endcase
        case ($urandom_range(15))
            0:       rst = pick_cv(32767);
            1:       rst = ONE_VOLT + 1;
            default: rst = $urandom_range(ONE_VOLT);
        endcase
        return pack_sample(sig, pick_cv(8000), pick_cv(12000), pick_cv(6000),
                           pick_cv(4000), trg, rst,
                           $urandom_range(3) == 0, $urandom_range(15) == 0);
    endfunction

    // offer one sample; called and returning at a falling edge
    task automatic send_item(input logic [IN_W-1:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(d);
        @(negedge aclk);
    endtask

    // hold the sender until every predicted result has come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // apb write: setup cycle, access cycle, then the bus returns to idle
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_knob(idx, value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_knobs(input int bias, input int rng, input int stp, input int ext);
        apb_write(REG_BIAS, bias);
        apb_write(REG_RANGE, rng);
        apb_write(REG_STEP, stp);
        apb_write(REG_EXT, ext);
    endtask

    initial begin
        sb = new();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part at the reset knobs: walls at -0.5 V and 2.5 V
        send_item(pack_sample(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(pack_sample(0, 0, 0, 0, 0, 0, 0, 1, 0));          // button trigger
        send_item(pack_sample(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(pack_sample(0, 0, 0, 0, 0, ONE_VOLT, 0, 0, 0));   // exactly 1 V is low
        send_item(pack_sample(0, 0, 0, 0, 0, ONE_VOLT + 1, 0, 0, 0));
        send_item(pack_sample(0, 0, 0, 0, 0, 0, 0, 0, 1));          // button reset
        send_item(pack_sample(0, 0, 0, 0, 0, 0, 0, 0, 1));          // held, no edge
        send_item(pack_sample(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(pack_sample(0, 0, 0, 0, 0, 0, 0, 1, 1));          // reset wins
        send_item(pack_sample(0, 0, 0, 0, 0, 0, 0, 0, 0));
        // zero range: step applies, bar is all or nothing
        send_item(pack_sample(0, 0, -3072, 0, 0, 0, 0, 1, 0));
        send_item(pack_sample(0, 0, -3072, 0, 0, 0, 0, 0, 0));
        send_item(pack_sample(0, 20000, -3072, 0, 0, 0, 0, 0, 0));
        // inverted step, lower wall inclusive
        send_item(pack_sample(0, 0, 0, 0, 1, 0, 0, 1, 0));
        send_item(pack_sample(0, 0, 0, 0, 1, 0, 0, 0, 0));
        // field extremes
        send_item(pack_sample(32767, 32767, 32767, 32767, 32767, 32767, 32767, 1, 1));
        send_item(pack_sample(-32768, -32768, -32768, -32768, -32768, -32768, -32768, 0, 0));
        send_item(pack_sample(32767, 32767, 32767, 32767, 32767, 32767, 32767, 1, 1));
        // negative range sum takes its magnitude
        send_item(pack_sample(0, 0, -20000, 0, 0, 0, 0, 0, 0));
        send_item(pack_sample(0, 0, -20000, 0, 0, 32767, 0, 0, 0));
        wait_for_results();

        // external sample on and just past both walls, both exclusive
        apb_write(REG_EXT, 32'd1);
        send_item(pack_sample(2560, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(pack_sample(2561, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(pack_sample(-512, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(pack_sample(-513, 0, 0, 0, 0, 0, 0, 1, 0));
        send_item(pack_sample(0, 0, 0, 0, 0, 0, 0, 0, 1));          // reset loads zero
        wait_for_results();

        // random phases, each with its own knobs and one of four idling patterns
        for (int ph = 0; ph < 9; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            case (ph)
                0: set_knobs(-5120, 0, -1024, 0);
                1: set_knobs(5120, 10240, 1024, 1);
                2: set_knobs(5120, 10240, 1024, 0);
                3: set_knobs(-5120, 10240, -1024, 1);
                6: set_knobs($urandom(), $urandom(), $urandom(), $urandom());
                default: set_knobs(int'($urandom_range(10240)) - 5120,
                                   $urandom_range(10240),
                                   int'($urandom_range(2048)) - 1024,
                                   $urandom_range(1));
            endcase
            if (ph == 4) begin
                // long receiver hold-off while samples keep coming
                hold_cycles = 400;
                repeat (16) send_item(random_sample());
            end
            repeat (100) send_item(random_sample());
            wait_for_results();
        end

        // catch any stray result transaction
        repeat (40) @(posedge aclk);
        if (sb.failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
src/wcs_pkg.sv
src/wcs_regs.sv
src/wcs_ctrl.sv
src/wcs_datapath.sv
src/window_comparator_stepper.sv
src/wcs_checker.sv
bench/testbench.sv
